[design/buddy_block_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared property templates for the allocator checks.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Codes, widths and state type shared by the allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_POOL_SIZE_LOG2 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_BLOCK_LOG2 = 8'd1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOSPACE  = 2'd1;
   localparam logic [1:0] ST_BADFREE  = 2'd2;
   localparam logic [1:0] ST_BADCFG   = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_SPLIT_TOP,
      S_SPLIT_LO,
      S_ALLOC_FIN,
      S_FREE_LV,
      S_MERGE_RD,
      S_MERGE_CHK,
      S_DONE
   } state_type;

endpackage

[design/bba_ifs.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator channels
// Request, response and register-write channel interfaces.
// ----------------------------------------------------------------------------
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] request_size;
   logic [31:0] release_offset;
   modport source (output valid, output operation, output request_size,
                   output release_offset, input ready);
   modport sink (input valid, input operation, input request_size,
                 input release_offset, output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [30:0] block_offset;
   logic [31:0] block_bytes;
   logic [31:0] used_bytes;
   logic [31:0] free_bytes;
   modport source (output valid, output status, output block_offset,
                   output block_bytes, output used_bytes, output free_bytes,
                   input ready);
   modport sink (input valid, input status, input block_offset,
                 input block_bytes, input used_bytes, input free_bytes,
                 output ready);
endinterface

interface bba_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bba_pkg::CSR_IDX_W-1:0]    index;
   logic [bba_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[design/bba_ram.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[design/bba_find_first.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator first-free search
// Finds the lowest set bit of one free-map row.
// ----------------------------------------------------------------------------
module bba_find_first #(
   parameter int unsigned WIDTH = 256,
   parameter int unsigned IDX_W = 8
) (
   input  logic [WIDTH-1:0] bits,
   output logic             found,
   output logic [IDX_W-1:0] index
);

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (bits[i]) begin
            found = 1'b1;
            index = IDX_W'(i);
         end
      end
   end

endmodule

[design/buddy_block_allocator.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over a power-of-two pool with a per-level free map.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch (allocate or free) and each produces exactly one
// response transaction on rsp_ch with status, granted offset and size, and the
// pool's used and free byte counts. Registers are written on csr_ch, which is
// always ready; a write to either register re-initializes the pool with only the root free.
// The free map holds one RAM row per tree level, so one request is handled at
// a time through the single read/modify/write path of the free-map RAM: an
// allocate reads and checks one level per search step, splits one level per
// step and records the owner; a free reads the owner level, then reads and
// checks the buddy row per level merged. After reset and after every register
// write a clearing pass rewrites the free map while req_ch is held not ready.
// The response is held in an output register; while the receiver stalls, the
// finished result waits and the next request is not started.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_assert.svh"

module buddy_block_allocator #(
   parameter int unsigned MAX_LEVELS = 9
) (
   input  logic      clock,
   input  logic      reset,
   bba_req_if.sink   req_ch,
   bba_rsp_if.source rsp_ch,
   bba_csr_if.sink   csr_ch
);

   localparam int unsigned LEAF_COUNT = 1 << (MAX_LEVELS - 1);
   localparam int unsigned IDX_W      = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;
   localparam int unsigned LV_W       = $clog2(MAX_LEVELS + 1);
   localparam int unsigned MAP_AW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   bba_pkg::state_type state_ff, state_in;

   logic [4:0]            pool_ff, minb_ff;
   logic [5:0]            diff6;
   logic                  cfg_ok;
   logic [LV_W-1:0]       lvl_cnt, lvl_top;
   logic [31:0]           capacity;

   logic                  op_ff;
   logic [31:0]           size_ff, off_ff;
   logic [LV_W-1:0]       want_ff, cur_lv_ff;
   logic [IDX_W-1:0]      cur_idx_ff;
   logic [LEAF_COUNT-1:0] row_ff;
   logic [1:0]            status_ff;
   logic [30:0]           boff_ff;
   logic [31:0]           bbytes_ff, used_ff;
   logic [LEAF_COUNT-1:0] leaf_valid_ff;

   logic                  clr_active_ff;
   logic [LV_W-1:0]       clr_row_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [30:0]           rsp_boff_ff;
   logic [31:0]           rsp_bbytes_ff, rsp_used_ff, rsp_free_ff;

   logic                  req_fire, csr_fire, rsp_load;
   logic [31:0]           size_m1;
   logic [5:0]            k6, want6;
   logic                  alloc_fit, free_bad;
   logic [IDX_W-1:0]      leaf_sel, alloc_leaf, buddy_idx;
   logic [LV_W-1:0]       owner_lv, lv_eff;
   logic [5:0]            free_shift, alloc_shift;

   logic                  map_we, map_re;
   logic [MAP_AW-1:0]     map_waddr, map_raddr;
   logic [LEAF_COUNT-1:0] map_wdata, map_rdata;
   logic                  own_we, own_re;
   logic [LV_W-1:0]       own_rdata;
   logic                  ff_found;
   logic [IDX_W-1:0]      ff_idx;
   logic                  buddy_free;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign diff6    = {1'b0, pool_ff} - {1'b0, minb_ff};
   assign cfg_ok   = (minb_ff <= pool_ff) && (diff6 < 6'(MAX_LEVELS));
   assign lvl_cnt  = LV_W'(diff6 + 6'd1);
   assign lvl_top  = LV_W'(diff6);
   assign capacity = 32'd1 << pool_ff;

   always_comb begin
      size_m1 = size_ff - 32'd1;
      k6 = '0;
      for (int i = 0; i < 32; i++) begin
         if (size_m1[i]) begin
            k6 = 6'(i + 1);
         end
      end
      if (size_ff <= 32'd1) begin
         k6 = '0;
      end
   end

   assign want6     = (k6 > {1'b0, minb_ff}) ? k6 - {1'b0, minb_ff} : 6'd0;
   assign alloc_fit = want6 < 6'(lvl_cnt);
   assign leaf_sel  = IDX_W'(off_ff >> minb_ff);
   assign free_bad  = ((off_ff >> pool_ff) != 32'd0) ||
                      ((off_ff & ((32'd1 << minb_ff) - 32'd1)) != 32'd0) ||
                      !leaf_valid_ff[leaf_sel];
   assign owner_lv  = own_rdata;
   assign lv_eff    = (owner_lv > lvl_top) ? lvl_top : owner_lv;
   assign free_shift  = 6'(minb_ff) + 6'(lv_eff);
   assign alloc_shift = 6'(minb_ff) + 6'(want_ff);
   assign alloc_leaf  = IDX_W'(cur_idx_ff << want_ff);
   assign buddy_idx   = cur_idx_ff ^ IDX_W'(1);
   assign buddy_free  = map_rdata[buddy_idx];

   bba_ram #(
      .WIDTH(LEAF_COUNT),
      .DEPTH(MAX_LEVELS)
   ) u_map_ram (
      .clock  (clock),
      .wr_en  (map_we),
      .wr_addr(map_waddr),
      .wr_data(map_wdata),
      .rd_en  (map_re),
      .rd_addr(map_raddr),
      .rd_data(map_rdata)
   );

   bba_ram #(
      .WIDTH(LV_W),
      .DEPTH(LEAF_COUNT)
   ) u_owner_ram (
      .clock  (clock),
      .wr_en  (own_we),
      .wr_addr(alloc_leaf),
      .wr_data(want_ff),
      .rd_en  (own_re),
      .rd_addr(leaf_sel),
      .rd_data(own_rdata)
   );

   bba_find_first #(
      .WIDTH(LEAF_COUNT),
      .IDX_W(IDX_W)
   ) u_find_first (
      .bits (map_rdata),
      .found(ff_found),
      .index(ff_idx)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::S_IDLE: begin
            if (req_fire) state_in = bba_pkg::S_DECODE;
         end
         bba_pkg::S_DECODE: begin
            if (!cfg_ok) begin
               state_in = bba_pkg::S_DONE;
            end else if (op_ff == bba_pkg::OP_ALLOC) begin
               state_in = alloc_fit ? bba_pkg::S_SRCH_RD : bba_pkg::S_DONE;
            end else begin
               state_in = free_bad ? bba_pkg::S_DONE : bba_pkg::S_FREE_LV;
            end
         end
         bba_pkg::S_SRCH_RD: state_in = bba_pkg::S_SRCH_CHK;
         bba_pkg::S_SRCH_CHK: begin
            if (ff_found) state_in = bba_pkg::S_SPLIT_TOP;
            else if (cur_lv_ff < lvl_top) state_in = bba_pkg::S_SRCH_RD;
            else state_in = bba_pkg::S_DONE;
         end
         bba_pkg::S_SPLIT_TOP, bba_pkg::S_SPLIT_LO: begin
            state_in = (cur_lv_ff == want_ff) ? bba_pkg::S_ALLOC_FIN
                                              : bba_pkg::S_SPLIT_LO;
         end
         bba_pkg::S_ALLOC_FIN: state_in = bba_pkg::S_DONE;
         bba_pkg::S_FREE_LV:   state_in = bba_pkg::S_MERGE_RD;
         bba_pkg::S_MERGE_RD:  state_in = bba_pkg::S_MERGE_CHK;
         bba_pkg::S_MERGE_CHK: begin
            state_in = (cur_lv_ff < lvl_top && buddy_free) ? bba_pkg::S_MERGE_RD
                                                           : bba_pkg::S_DONE;
         end
         bba_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = bba_pkg::S_IDLE;
         end
         default: state_in = bba_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      rsp_load     = 1'b0;
      map_we       = 1'b0;
      map_waddr    = cur_lv_ff[MAP_AW-1:0];
      map_wdata    = '0;
      map_re       = 1'b0;
      map_raddr    = cur_lv_ff[MAP_AW-1:0];
      own_we       = 1'b0;
      own_re       = 1'b0;
      unique case (state_ff)
         bba_pkg::S_IDLE: req_ch.ready = !clr_active_ff;
         bba_pkg::S_DECODE: own_re = 1'b1;
         bba_pkg::S_SRCH_RD, bba_pkg::S_MERGE_RD: map_re = 1'b1;
         bba_pkg::S_SPLIT_TOP: begin
            map_we    = 1'b1;
            map_wdata = row_ff;
         end
         bba_pkg::S_SPLIT_LO: begin
            map_we    = 1'b1;
            map_wdata = LEAF_COUNT'(1) << (cur_idx_ff | IDX_W'(1));
         end
         bba_pkg::S_ALLOC_FIN: own_we = 1'b1;
         bba_pkg::S_MERGE_CHK: begin
            map_we = 1'b1;
            if (cur_lv_ff < lvl_top && buddy_free) begin
               map_wdata = map_rdata & ~(LEAF_COUNT'(1) << cur_idx_ff)
                                     & ~(LEAF_COUNT'(1) << buddy_idx);
            end else begin
               map_wdata = map_rdata | (LEAF_COUNT'(1) << cur_idx_ff);
            end
         end
         bba_pkg::S_DONE: rsp_load = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
      if (clr_active_ff) begin
         map_we    = 1'b1;
         map_waddr = clr_row_ff[MAP_AW-1:0];
         map_wdata = (cfg_ok && clr_row_ff == lvl_top) ? LEAF_COUNT'(1)
                                                      : LEAF_COUNT'(0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bba_pkg::S_IDLE;
         pool_ff       <= 5'd8;
         minb_ff       <= 5'd0;
         used_ff       <= '0;
         leaf_valid_ff <= '0;
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clr_active_ff) begin
            if (clr_row_ff == LV_W'(MAX_LEVELS - 1)) clr_active_ff <= 1'b0;
            clr_row_ff <= clr_row_ff + LV_W'(1);
         end
         if (csr_fire && (csr_ch.index == bba_pkg::REG_POOL_SIZE_LOG2 ||
                          csr_ch.index == bba_pkg::REG_MIN_BLOCK_LOG2)) begin
            if (csr_ch.index == bba_pkg::REG_POOL_SIZE_LOG2) pool_ff <= csr_ch.data[4:0];
            else minb_ff <= csr_ch.data[4:0];
            used_ff       <= '0;
            leaf_valid_ff <= '0;
            clr_active_ff <= 1'b1;
            clr_row_ff    <= '0;
         end
         if (state_ff == bba_pkg::S_ALLOC_FIN) begin
            leaf_valid_ff[alloc_leaf] <= 1'b1;
            used_ff <= used_ff + (32'd1 << alloc_shift);
         end
         if (state_ff == bba_pkg::S_FREE_LV) begin
            leaf_valid_ff[leaf_sel] <= 1'b0;
            used_ff <= used_ff - (32'd1 << free_shift);
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_ch.operation;
         size_ff <= req_ch.request_size;
         off_ff  <= req_ch.release_offset;
      end
      case (state_ff)
         bba_pkg::S_DECODE: begin
            status_ff <= bba_pkg::ST_OK;
            boff_ff   <= '0;
            bbytes_ff <= '0;
            want_ff   <= LV_W'(want6);
            cur_lv_ff <= LV_W'(want6);
            if (!cfg_ok) status_ff <= bba_pkg::ST_BADCFG;
            else if (op_ff == bba_pkg::OP_ALLOC && !alloc_fit) status_ff <= bba_pkg::ST_NOSPACE;
            else if (op_ff == bba_pkg::OP_FREE && free_bad) status_ff <= bba_pkg::ST_BADFREE;
         end
         bba_pkg::S_SRCH_CHK: begin
            if (ff_found) begin
               cur_idx_ff <= ff_idx;
               row_ff     <= map_rdata & ~(LEAF_COUNT'(1) << ff_idx);
            end else if (cur_lv_ff < lvl_top) begin
               cur_lv_ff <= cur_lv_ff + LV_W'(1);
            end else begin
               status_ff <= bba_pkg::ST_NOSPACE;
            end
         end
         bba_pkg::S_SPLIT_TOP, bba_pkg::S_SPLIT_LO: begin
            if (cur_lv_ff != want_ff) begin
               cur_lv_ff  <= cur_lv_ff - LV_W'(1);
               cur_idx_ff <= cur_idx_ff << 1;
            end
         end
         bba_pkg::S_ALLOC_FIN: begin
            bbytes_ff <= 32'd1 << alloc_shift;
            boff_ff   <= 31'(cur_idx_ff) << alloc_shift;
         end
         bba_pkg::S_FREE_LV: begin
            bbytes_ff  <= 32'd1 << free_shift;
            cur_lv_ff  <= lv_eff;
            cur_idx_ff <= IDX_W'(off_ff >> free_shift);
         end
         bba_pkg::S_MERGE_CHK: begin
            if (cur_lv_ff < lvl_top && buddy_free) begin
               cur_lv_ff  <= cur_lv_ff + LV_W'(1);
               cur_idx_ff <= cur_idx_ff >> 1;
            end
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_boff_ff   <= boff_ff;
         rsp_bbytes_ff <= bbytes_ff;
         rsp_used_ff   <= used_ff;
         rsp_free_ff   <= cfg_ok ? capacity - used_ff : 32'd0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.block_offset = rsp_boff_ff;
   assign rsp_ch.block_bytes  = rsp_bbytes_ff;
   assign rsp_ch.used_bytes   = rsp_used_ff;
   assign rsp_ch.free_bytes   = rsp_free_ff;

   `BBA_ASSERT_NOW(a_used_in_pool, clock, reset, cfg_ok, used_ff <= capacity, "used bytes exceed pool")
   `BBA_ASSERT_NOW(a_badcfg_empty, clock, reset, !cfg_ok, used_ff == 32'd0, "used bytes under bad configuration")
   `BBA_ASSERT_NOW(a_free_owned, clock, reset, state_ff == bba_pkg::S_FREE_LV, leaf_valid_ff[leaf_sel], "free of unowned leaf")
   `BBA_ASSERT_NEXT(a_rsp_loaded, clock, reset, rsp_load, rsp_valid_ff && state_ff == bba_pkg::S_IDLE, "response not presented")

endmodule

[tb/bba_tb_ifs.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench channels
// The channel interfaces are taken from the design; this file holds only the
// shared monitor record used by the testbench.
// ----------------------------------------------------------------------------
package bba_tb_pkg;

   typedef struct packed {
      logic [1:0]  status;
      logic [30:0] block_offset;
      logic [31:0] block_bytes;
      logic [31:0] used_bytes;
      logic [31:0] free_bytes;
   } grant_type;

endpackage

[tb/buddy_block_allocator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free transactions under several pool settings, predicts
// each response with a behavioral buddy tree, and compares every response
// field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb;

   localparam int unsigned LEVELS = 9;
   localparam int unsigned NODES = 1 << LEVELS;
   localparam int unsigned LEAVES = 1 << (LEVELS - 1);
   localparam int unsigned WATCH_LIMIT = 20000;

   typedef struct packed {
      logic        operation;
      logic [31:0] request_size;
      logic [31:0] release_offset;
   } request_type;

   logic clock;
   logic reset;

   bba_req_if req_ch ();
   bba_rsp_if rsp_ch ();
   bba_csr_if csr_ch ();

   buddy_block_allocator #(.MAX_LEVELS(LEVELS)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Predictor state.
   logic [4:0]  pool_log2;
   logic [4:0]  minb_log2;
   bit          node_free [NODES];
   bit [3:0]    leaf_level [LEAVES];
   bit          leaf_held [LEAVES];
   logic [31:0] used_total;
   bit          cfg_ok;
   int unsigned level_count;

   request_type           pending_requests [$];
   bba_tb_pkg::grant_type expected_grants [$];
   logic [31:0]           live_offsets [$];

   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_cycles;
   int  watch_count;
   int  error_count;
   bit  stimulus_done;

   function automatic int unsigned node_index(int unsigned lv, int unsigned idx);
      return ((1 << (level_count - lv - 1)) + idx) & (NODES - 1);
   endfunction

   function automatic void rebuild_pool();
      foreach (node_free[i]) node_free[i] = 0;
      foreach (leaf_level[i]) begin
         leaf_level[i] = 0;
         leaf_held[i] = 0;
      end
      used_total = 0;
      cfg_ok = 0;
      level_count = 0;
      live_offsets.delete();
      if (minb_log2 > pool_log2) return;
      level_count = pool_log2 - minb_log2 + 1;
      if (level_count > LEVELS) begin
         level_count = 0;
         return;
      end
      cfg_ok = 1;
      node_free[1] = 1;
   endfunction

   function automatic bba_tb_pkg::grant_type predict_grant(request_type r);
      bba_tb_pkg::grant_type g;
      int unsigned k, want, lv, found_lv, idx, n, leaf, parent, left;
      bit found;
      logic [63:0] cap;
      g = '0;
      cap = 64'd1 << pool_log2;
      if (!cfg_ok) begin
         g.status = bba_pkg::ST_BADCFG;
      end else if (r.operation == bba_pkg::OP_ALLOC) begin
         k = 0;
         found = 0;
         found_lv = 0;
         idx = 0;
         while (k < 32 && (64'd1 << k) < {32'd0, r.request_size}) k++;
         want = (k > minb_log2) ? k - minb_log2 : 0;
         if (want < level_count) begin
            for (lv = want; lv < level_count && !found; lv++) begin
               n = 1 << (level_count - 1 - lv);
               for (int unsigned i = 0; i < n && !found; i++) begin
                  if (node_free[node_index(lv, i)]) begin
                     found = 1;
                     found_lv = lv;
                     idx = i;
                  end
               end
            end
         end
         if (!found) begin
            g.status = bba_pkg::ST_NOSPACE;
         end else begin
            for (lv = found_lv; lv > want; lv--) begin
               node_free[node_index(lv, idx)] = 0;
               idx = idx * 2;
               node_free[node_index(lv - 1, idx)] = 1;
               node_free[node_index(lv - 1, idx + 1)] = 1;
            end
            node_free[node_index(want, idx)] = 0;
            g.block_bytes = 32'((64'd1 << (minb_log2 + want)));
            g.block_offset = 31'((64'(idx) << (minb_log2 + want)));
            used_total += g.block_bytes;
            leaf = (32'(g.block_offset) >> minb_log2) & (LEAVES - 1);
            leaf_level[leaf] = want;
            leaf_held[leaf] = 1;
            live_offsets.push_back(32'(g.block_offset));
         end
      end else begin
         if ({32'd0, r.release_offset} >= cap ||
             (r.release_offset & ((32'd1 << minb_log2) - 1)) != 0) begin
            g.status = bba_pkg::ST_BADFREE;
         end else begin
            leaf = (r.release_offset >> minb_log2) & (LEAVES - 1);
            if (!leaf_held[leaf]) begin
               g.status = bba_pkg::ST_BADFREE;
            end else begin
               lv = leaf_level[leaf];
               leaf_held[leaf] = 0;
               leaf_level[leaf] = 0;
               if (lv >= level_count) lv = level_count - 1;
               g.block_bytes = 32'((64'd1 << (minb_log2 + lv)));
               idx = r.release_offset >> (minb_log2 + lv);
               node_free[node_index(lv, idx)] = 1;
               parent = idx >> 1;
               for (int unsigned l = lv + 1; l < level_count; l++) begin
                  left = parent * 2;
                  if (!node_free[node_index(l - 1, left)] ||
                      !node_free[node_index(l - 1, left + 1)]) break;
                  node_free[node_index(l - 1, left)] = 0;
                  node_free[node_index(l - 1, left + 1)] = 0;
                  node_free[node_index(l, parent)] = 1;
                  parent = parent >> 1;
               end
               used_total -= g.block_bytes;
               foreach (live_offsets[i]) begin
                  if (live_offsets[i] == r.release_offset) begin
                     live_offsets.delete(i);
                     break;
                  end
               end
            end
         end
      end
      g.used_bytes = used_total;
      g.free_bytes = cfg_ok ? 32'(cap - {32'd0, used_total}) : 32'd0;
      return g;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1;
            req_ch.operation <= pending_requests[0].operation;
            req_ch.request_size <= pending_requests[0].request_size;
            req_ch.release_offset <= pending_requests[0].release_offset;
            void'(pending_requests.pop_front());
         end else begin
            req_ch.valid <= 0;
         end
      end
   end

   // Receiver readiness, including long holds.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (hold_cycles > 0) begin
         rsp_ch.ready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Prediction at acceptance and response checking.
   always @(posedge clock) begin
      bba_tb_pkg::grant_type got;
      bba_tb_pkg::grant_type want;
      request_type r;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            r.operation = req_ch.operation;
            r.request_size = req_ch.request_size;
            r.release_offset = req_ch.release_offset;
            expected_grants.push_back(predict_grant(r));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.block_offset = rsp_ch.block_offset;
            got.block_bytes = rsp_ch.block_bytes;
            got.used_bytes = rsp_ch.used_bytes;
            got.free_bytes = rsp_ch.free_bytes;
            if (expected_grants.size() == 0) begin
               $display("%0t: unexpected response, actual %h", $time, got);
               error_count++;
            end else begin
               want = expected_grants.pop_front();
               if (got.status !== want.status)
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got.status);
               if (got.block_offset !== want.block_offset)
                  $display("%0t: block_offset expected %h actual %h", $time,
                           want.block_offset, got.block_offset);
               if (got.block_bytes !== want.block_bytes)
                  $display("%0t: block_bytes expected %h actual %h", $time,
                           want.block_bytes, got.block_bytes);
               if (got.used_bytes !== want.used_bytes)
                  $display("%0t: used_bytes expected %h actual %h", $time,
                           want.used_bytes, got.used_bytes);
               if (got.free_bytes !== want.free_bytes)
                  $display("%0t: free_bytes expected %h actual %h", $time,
                           want.free_bytes, got.free_bytes);
               if (got !== want) error_count++;
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready) || stimulus_done)
            watch_count <= 0;
         else
            watch_count <= watch_count + 1;
         if (watch_count >= WATCH_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic wait_clocks(int n);
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_responses();
      while (pending_requests.size() > 0 || req_ch.valid || expected_grants.size() > 0)
         @(posedge clock);
      wait_clocks(3 * LEVELS + 10);
   endtask

   task automatic write_register(logic [bba_pkg::CSR_IDX_W-1:0] idx, logic [4:0] value);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data <= {$urandom_range(1) ? 27'h5ffffff : 27'd0, value};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 0;
      if (idx == bba_pkg::REG_POOL_SIZE_LOG2) pool_log2 = value;
      else minb_log2 = value;
      rebuild_pool();
      wait_clocks(LEVELS + 4);
   endtask

   task automatic queue_request(bit op, logic [31:0] size, logic [31:0] offset);
      request_type r;
      r.operation = op;
      r.request_size = size;
      r.release_offset = offset;
      pending_requests.push_back(r);
   endtask

   function automatic logic [31:0] random_size();
      int unsigned k;
      k = $urandom_range(pool_log2 > 0 ? pool_log2 : 1);
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom;
         default: return $urandom_range(1 << k, k > 0 ? (1 << (k - 1)) + 1 : 0);
      endcase
   endfunction

   // Random phase: a mix of allocates and frees of aligned offsets, with random-offset frees as noise.
   task automatic random_phase(int count);
      logic [31:0] pick;
      for (int i = 0; i < count; i++) begin
         int sel;
         sel = $urandom_range(9);
         if (sel < 5) begin
            queue_request(bba_pkg::OP_ALLOC, random_size(), $urandom);
         end else if (sel < 9) begin
            pick = $urandom_range((1 << pool_log2) - 1);
            pick = (pick >> minb_log2) << minb_log2;
            // Bias toward aligned offsets of moderate block sizes.
            pick = (pick >> ($urandom_range(3) + minb_log2)) << ($urandom_range(3) + minb_log2);
            queue_request(bba_pkg::OP_FREE, $urandom, pick & ((1 << pool_log2) - 1));
         end else begin
            queue_request(bba_pkg::OP_FREE, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      reset = 1;
      req_ch.valid = 0;
      req_ch.operation = 0;
      req_ch.request_size = 0;
      req_ch.release_offset = 0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0;
      csr_ch.index = 0;
      csr_ch.data = 0;
      send_idle_pct = 21;
      recv_idle_pct = 80;
      hold_cycles = 0;
      watch_count = 0;
      error_count = 0;
      stimulus_done = 0;
      pool_log2 = 8;
      minb_log2 = 0;
      rebuild_pool();
      wait_clocks(8);
      reset <= 0;
      wait_clocks(LEVELS + 4);

      // Directed: default pool of 256 bytes with one-byte minimum.
      queue_request(bba_pkg::OP_ALLOC, 0, 0);
      queue_request(bba_pkg::OP_ALLOC, 32'hffff_ffff, 0);
      queue_request(bba_pkg::OP_ALLOC, 256, 0);
      queue_request(bba_pkg::OP_ALLOC, 257, 0);
      queue_request(bba_pkg::OP_FREE, 0, 0);
      queue_request(bba_pkg::OP_FREE, 0, 0);
      queue_request(bba_pkg::OP_ALLOC, 3, 0);
      queue_request(bba_pkg::OP_ALLOC, 1, 0);
      queue_request(bba_pkg::OP_ALLOC, 100, 0);
      queue_request(bba_pkg::OP_FREE, 0, 32'hffff_ffff);
      queue_request(bba_pkg::OP_FREE, 0, 256);
      queue_request(bba_pkg::OP_FREE, 0, 4);
      queue_request(bba_pkg::OP_FREE, 0, 0);
      queue_request(bba_pkg::OP_FREE, 0, 128);
      queue_request(bba_pkg::OP_FREE, 0, 5);
      for (int i = 0; i < 6; i++) queue_request(bba_pkg::OP_ALLOC, 32, 0);
      queue_request(bba_pkg::OP_FREE, 32'hffff_ffff, 32'h8000_0000);
      drain_responses();

      // Long receiver hold while the sender keeps offering.
      hold_cycles = 400;
      random_phase(40);
      drain_responses();

      // Bad configurations, then the extremes.
      write_register(bba_pkg::REG_MIN_BLOCK_LOG2, 31);
      queue_request(bba_pkg::OP_ALLOC, 1, 0);
      queue_request(bba_pkg::OP_FREE, 0, 0);
      drain_responses();
      write_register(bba_pkg::REG_POOL_SIZE_LOG2, 31);
      queue_request(bba_pkg::OP_ALLOC, 0, 0);
      queue_request(bba_pkg::OP_ALLOC, 32'h8000_0001, 0);
      queue_request(bba_pkg::OP_FREE, 0, 0);
      queue_request(bba_pkg::OP_FREE, 0, 32'h4000_0000);
      random_phase(20);
      drain_responses();
      write_register(bba_pkg::REG_MIN_BLOCK_LOG2, 0);
      queue_request(bba_pkg::OP_ALLOC, 4, 0);
      drain_responses();
      write_register(bba_pkg::REG_MIN_BLOCK_LOG2, 23);
      random_phase(120);
      drain_responses();
      write_register(bba_pkg::REG_POOL_SIZE_LOG2, 0);
      write_register(bba_pkg::REG_MIN_BLOCK_LOG2, 0);
      random_phase(20);
      drain_responses();

      send_idle_pct = 80;
      recv_idle_pct = 21;
      write_register(bba_pkg::REG_POOL_SIZE_LOG2, 8);
      write_register(bba_pkg::REG_MIN_BLOCK_LOG2, 1);
      random_phase(200);
      drain_responses();
      write_register(bba_pkg::REG_POOL_SIZE_LOG2, 12);
      write_register(bba_pkg::REG_MIN_BLOCK_LOG2, 4);
      random_phase(200);
      drain_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(bba_pkg::REG_POOL_SIZE_LOG2, 5);
      write_register(bba_pkg::REG_MIN_BLOCK_LOG2, 2);
      random_phase(100);
      drain_responses();
      write_register(bba_pkg::REG_POOL_SIZE_LOG2, 8);
      write_register(bba_pkg::REG_MIN_BLOCK_LOG2, 0);
      random_phase(150);
      drain_responses();

      stimulus_done = 1;
      if (error_count == 0 && expected_grants.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
